// ===== rtl/dsis_pkg.sv =====
// ----------------------------------------------------------------------------
// dsis_pkg
// Shared types and constants for the descending stable insertion sorter.
// ----------------------------------------------------------------------------
package dsis_pkg;

  // Number of cells in the chain
  localparam int unsigned DEPTH = 16;
  localparam int unsigned KEY_W = 16;
  localparam int unsigned TAG_W = 40;

  // One stored record
  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } rec_t;

  // Chain-wide control broadcast to every cell
  typedef struct packed {
    logic ins_en;    // insert the broadcast record this cycle
    logic drain_en;  // shift the chain one place towards cell 0
  } ctrl_t;

endpackage

// ===== rtl/dsis_if.sv =====
// ----------------------------------------------------------------------------
// dsis_if
// Valid/ready channel interfaces for record input and sorted output.
// ----------------------------------------------------------------------------
interface dsis_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [dsis_pkg::KEY_W-1:0] sort_key;
  logic [dsis_pkg::TAG_W-1:0]        record_tag;
  logic                              last_item;

  modport source (output valid, sort_key, record_tag, last_item, input ready);
  modport sink   (input valid, sort_key, record_tag, last_item, output ready);
endinterface

interface dsis_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [dsis_pkg::KEY_W-1:0] out_key;
  logic [dsis_pkg::TAG_W-1:0]        out_tag;
  logic                              run_end;
  logic                              overflow;

  modport source (output valid, out_key, out_tag, run_end, overflow, input ready);
  modport sink   (input valid, out_key, out_tag, run_end, overflow, output ready);
endinterface

// ===== rtl/descending_stable_insertion_sorter.sv =====
// ----------------------------------------------------------------------------
// descending_stable_insertion_sorter
// Stable descending insertion sort over a chain of DEPTH cells; the run is
// emitted from cell 0 once the record marked last has been taken.
// ----------------------------------------------------------------------------
//  Channel   Dir   Fields                                  Handshake
//  in_ch     in    sort_key, record_tag, last_item         valid/ready
//  out_ch    out   out_key, out_tag, run_end, overflow     valid/ready
//
//  Loading: one record per cycle; the broadcast compare in every cell and the
//  one-place shift of the chain place it in the same cycle.
//  Emission: after a last record, one result per cycle from cell 0 while the
//  sink is ready; input is held off (in_ch.ready low) until run_end is taken.
//  Reset clears every cell's valid bit at once; no clearing pass.
//  A sink stall simply freezes the chain; cell 0 holds the waiting result.
module descending_stable_insertion_sorter (
  input logic        clk,
  input logic        rst_n,
  dsis_in_if.sink    in_ch,
  dsis_out_if.source out_ch
);

  localparam int unsigned N = dsis_pkg::DEPTH;

  dsis_pkg::rec_t  cell_q  [N];
  logic            ins     [N];
  dsis_pkg::rec_t  new_rec;
  dsis_pkg::ctrl_t ctrl;

  logic draining_r, draining_nxt;
  logic dropped_r, dropped_nxt;
  logic in_acc, out_acc, full;

  assign full    = cell_q[N-1].valid;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // Broadcast record
  assign new_rec.valid = 1'b1;
  assign new_rec.key   = in_ch.sort_key;
  assign new_rec.tag   = in_ch.record_tag;

  assign ctrl.ins_en   = in_acc && !full;
  assign ctrl.drain_en = out_acc;

  // Cell chain
  for (genvar i = 0; i < N; i++) begin : g_cell
    dsis_pkg::rec_t prev_r, next_r;
    logic           prev_i;
    if (i == 0) begin : g_head
      assign prev_r = '0;
      assign prev_i = 1'b0;
    end else begin : g_body
      assign prev_r = cell_q[i-1];
      assign prev_i = ins[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign next_r = '0;
    end else begin : g_mid
      assign next_r = cell_q[i+1];
    end
    dsis_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .new_rec  (new_rec),
      .prev_rec (prev_r),
      .prev_ins (prev_i),
      .next_rec (next_r),
      .cur      (cell_q[i]),
      .ins_o    (ins[i])
    );
  end

  // Run control
  always_comb begin
    draining_nxt = draining_r;
    dropped_nxt  = dropped_r;
    if (in_acc) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end
      if (in_ch.last_item) begin
        draining_nxt = 1'b1;
      end
    end
    if (out_acc && out_ch.run_end) begin
      draining_nxt = 1'b0;
      dropped_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draining_r <= 1'b0;
      dropped_r  <= 1'b0;
    end else begin
      draining_r <= draining_nxt;
      dropped_r  <= dropped_nxt;
    end
  end

  // Ports
  assign in_ch.ready     = !draining_r;
  assign out_ch.valid    = draining_r && cell_q[0].valid;
  assign out_ch.out_key  = cell_q[0].key;
  assign out_ch.out_tag  = cell_q[0].tag;
  assign out_ch.run_end  = !cell_q[1].valid;
  assign out_ch.overflow = dropped_r;

endmodule

// ===== rtl/dsis_cell.sv =====
// ----------------------------------------------------------------------------
// dsis_cell
// One slot of the insertion chain: holds a record, compares it against the
// broadcast record and takes its own, its left or its right neighbour's data.
// ----------------------------------------------------------------------------
module dsis_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  dsis_pkg::ctrl_t ctrl,
  input  dsis_pkg::rec_t  new_rec,   // broadcast record being inserted
  input  dsis_pkg::rec_t  prev_rec,  // left neighbour (larger or equal keys)
  input  logic            prev_ins,  // left neighbour is displaced
  input  dsis_pkg::rec_t  next_rec,  // right neighbour, used when draining
  output dsis_pkg::rec_t  cur,
  output logic            ins_o
);

  logic                              valid_r, valid_nxt;
  logic signed [dsis_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [dsis_pkg::TAG_W-1:0]        tag_r, tag_nxt;

  // Strict compare: equal keys stay ahead of the newcomer
  assign ins_o = ctrl.ins_en && (!valid_r || (new_rec.key > key_r));

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    tag_nxt   = tag_r;
    if (ctrl.drain_en) begin
      valid_nxt = next_rec.valid;
      key_nxt   = next_rec.key;
      tag_nxt   = next_rec.tag;
    end else if (ctrl.ins_en && prev_ins) begin
      // shift right to make room further up
      valid_nxt = prev_rec.valid;
      key_nxt   = prev_rec.key;
      tag_nxt   = prev_rec.tag;
    end else if (ins_o) begin
      valid_nxt = 1'b1;
      key_nxt   = new_rec.key;
      tag_nxt   = new_rec.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset; valid guards it
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    tag_r <= tag_nxt;
  end

  assign cur.valid = valid_r;
  assign cur.key   = key_r;
  assign cur.tag   = tag_r;

endmodule
